@@ design/block_run_dedup_writer_defines.svh @@
// Assertion macros for the block run dedup writer.
// Used by the checker module; depends on nothing else.
`ifndef BLOCK_RUN_DEDUP_WRITER_DEFINES_SVH
`define BLOCK_RUN_DEDUP_WRITER_DEFINES_SVH
// implication checked at every clock edge outside reset
`define BRDW_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: lbl failed");
// next-cycle implication
`define BRDW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: lbl failed");
`endif

@@ design/brdw_pkg.sv @@
// Package for the block run dedup writer: widths, table constants and state codes.
// Standalone; used by the top level and its modulo unit.
package brdw_pkg;
  localparam int TableDepth  = 1024;
  localparam int IdxBits     = $clog2(TableDepth);
  localparam int CntBits     = IdxBits + 1;
  localparam int OfsBits     = 48;
  localparam int SizeBits    = 24;
  localparam int HashBits    = 57;
  localparam int DbsBits     = 21;
  localparam logic [DbsBits-1:0] DbsReset = DbsBits'(4096);

  typedef enum logic [4:0] {
    S_IDLE, S_PAD1_DIV, S_PAD1_WAIT, S_PAD1_APPLY, S_BLOCK, S_PAD2_DIV, S_PAD2_WAIT,
    S_PAD2_APPLY, S_DD_START, S_DD_RD, S_DD_CMP, S_DD_CUT_RD, S_DD_CUT_WAIT,
    S_DD_CUT, S_LOC_RD, S_LOC_WAIT, S_OUT
  } state_e;

  typedef struct packed {
    logic start;
  } mod_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DbsBits-1:0]  rem;
  } mod_rsp_t;
endpackage

@@ design/block_run_dedup_writer.sv @@
// Block run dedup writer: appends block write events to an image, pads file
// boundaries to the device block size and folds repeated runs of block hashes.
// Depends on brdw_pkg and brdw_mod.
//
// Usage: one input beat per block event (valid/ready on the *_i fields), one
// result beat (location, image end, status) per event on the output channel.
// The device block size register is written through cfg_we_i/cfg_wdata_i; the
// user must write it only while idle, the block does not enforce this. It
// resets to 4096. An ordinary block passes PAD1_DIV, BLOCK and PAD2_DIV to OUT;
// in_ready_o rises the cycle after the result beat leaves. A padding step with
// align set and a nonzero block size runs the bit-serial modulo unit (48 steps).
// A last block with a nonempty run and no_dedup clear walks the record table:
// for each earlier start i, up to run-length compares, each through the single
// read port of the hash memory. The block takes one event at a time; in_ready_o
// is low until the result beat has left. The result register holds while the
// receiver stalls.
// Reset clears record count, run start and image end; the record memories
// are not cleared and need no clearing pass, since only written entries are read.
module block_run_dedup_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brdw_pkg::DbsBits-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [brdw_pkg::SizeBits-1:0] block_size_i,
  input  logic [31:0]                   checksum_i,
  input  logic                          first_block_i,
  input  logic                          last_block_i,
  input  logic                          fragment_block_i,
  input  logic                          is_sparse_i,
  input  logic                          is_compressed_i,
  input  logic                          align_i,
  input  logic                          no_dedup_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brdw_pkg::OfsBits-1:0]  location_o,
  output logic [brdw_pkg::OfsBits-1:0]  image_end_o,
  output logic                          status_o
);
  import brdw_pkg::*;

  // record memories
  logic [OfsBits-1:0]  ofs_mem [TableDepth];
  logic [HashBits-1:0] hash_mem [TableDepth];
  logic                we;
  logic [IdxBits-1:0]  waddr, raddr;
  logic [OfsBits-1:0]  wofs, rofs_q;
  logic [HashBits-1:0] whash, rhash_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      ofs_mem[waddr]  <= wofs;
      hash_mem[waddr] <= whash;
    end
    rofs_q  <= ofs_mem[raddr];
    rhash_q <= hash_mem[raddr];
  end

  state_e state_q, state_d;
  logic [DbsBits-1:0]  dbs_q;
  logic [CntBits-1:0]  cnt_q, cnt_d, run_q, run_d;
  logic [OfsBits-1:0]  fsize_q, fsize_d, loc_q, loc_d;
  logic                err_q, err_d;
  // latched beat
  logic [SizeBits-1:0] bs_q;
  logic [31:0]         cs_q;
  logic                first_q, last_q, frag_q, sparse_q, comp_q, align_q, nodd_q;
  // search
  logic [CntBits-1:0]  i_q, i_d, j_q, j_d, len_q, len_d;
  logic [HashBits-1:0] ha_q, ha_d;
  logic                phase_q, phase_d;
  logic [CntBits-1:0]  used;

  mod_req_t mreq;
  mod_rsp_t mrsp;

  brdw_mod u_mod (
    .clk_i, .rst_ni, .req_i(mreq), .dividend_i(fsize_q), .divisor_i(dbs_q), .rsp_o(mrsp)
  );

  logic pad_needed;
  assign pad_needed = align_q && (dbs_q != '0);
  assign used = (len_q >= (run_q - i_q)) ? i_q + len_q : run_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (in_valid_i) state_d = S_PAD1_DIV;
      S_PAD1_DIV:   state_d = (!(first_q || frag_q)) ? S_BLOCK :
                              (pad_needed ? S_PAD1_WAIT : S_PAD1_APPLY);
      S_PAD1_WAIT:  if (mrsp.done) state_d = S_PAD1_APPLY;
      S_PAD1_APPLY: state_d = err_d ? S_OUT : S_BLOCK;
      S_BLOCK:      state_d = err_d ? S_OUT : S_PAD2_DIV;
      S_PAD2_DIV:   state_d = (!(last_q || frag_q)) ? S_OUT :
                              (pad_needed ? S_PAD2_WAIT : S_PAD2_APPLY);
      S_PAD2_WAIT:  if (mrsp.done) state_d = S_PAD2_APPLY;
      S_PAD2_APPLY: state_d = (err_d || !last_q) ? S_OUT : S_DD_START;
      S_DD_START:   state_d = (cnt_q <= run_q) ? S_OUT : (nodd_q ? S_LOC_RD : S_DD_RD);
      S_DD_RD:      state_d = (i_q >= run_q) ? S_LOC_RD : S_DD_CMP;
      S_DD_CMP:     state_d = phase_q ? S_DD_RD : S_DD_CMP;
      S_DD_CUT_RD:  state_d = S_DD_CUT_WAIT;
      S_DD_CUT_WAIT: state_d = S_DD_CUT;
      S_DD_CUT:     state_d = S_LOC_RD;
      S_LOC_RD:     state_d = S_LOC_WAIT;
      S_LOC_WAIT:   state_d = S_OUT;
      S_OUT:        if (out_ready_i) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
    // match found overrides the compare loop exit
    if (state_q == S_DD_CMP && phase_q && j_q == len_q - 1'b1 &&
        rhash_q == ha_q && ha_q != '0) state_d = S_DD_CUT_RD;
  end

  // datapath and outputs
  always_comb begin
    cnt_d = cnt_q; run_d = run_q; fsize_d = fsize_q; loc_d = loc_q; err_d = err_q;
    i_d = i_q; j_d = j_q; len_d = len_q; ha_d = ha_q; phase_d = phase_q;
    we = 1'b0; waddr = cnt_q[IdxBits-1:0]; wofs = fsize_q; whash = '0;
    raddr = '0; mreq.start = 1'b0;
    case (state_q)
      S_IDLE: err_d = 1'b0;
      S_PAD1_DIV, S_PAD2_DIV: mreq.start = pad_needed &&
        (state_q == S_PAD1_DIV ? (first_q || frag_q) : (last_q || frag_q));
      S_PAD1_APPLY, S_PAD2_APPLY: begin
        if (pad_needed && mrsp.rem != '0) begin
          fsize_d = fsize_q + OfsBits'(dbs_q - mrsp.rem);
          if (cnt_q >= CntBits'(TableDepth)) err_d = 1'b1;
          else begin
            we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (!err_d && state_q == S_PAD1_APPLY && first_q) run_d = cnt_d;
      end
      S_BLOCK: begin
        loc_d = fsize_q;
        if (bs_q != '0 && !sparse_q) begin
          if (cnt_q >= CntBits'(TableDepth)) err_d = 1'b1;
          else begin
            we = 1'b1;
            whash = {!comp_q, bs_q, cs_q};
            cnt_d = cnt_q + 1'b1;
            fsize_d = fsize_q + OfsBits'(bs_q);
          end
        end
      end
      S_DD_START: begin
        len_d = cnt_q - run_q;
        // no search: park i on the run start so the run's own offset is read
        i_d = nodd_q ? run_q : '0;
        j_d = '0;
        if (cnt_q <= run_q) loc_d = '0;
      end
      S_DD_RD: begin
        raddr = IdxBits'(i_q + j_q);
        phase_d = 1'b0;
      end
      S_DD_CMP: begin
        if (!phase_q) begin
          ha_d = rhash_q;
          raddr = IdxBits'(run_q + j_q);
          phase_d = 1'b1;
        end else begin
          if (rhash_q == ha_q && ha_q != '0 && j_q != len_q - 1'b1) begin
            j_d = j_q + 1'b1;
          end else if (!(rhash_q == ha_q && ha_q != '0)) begin
            j_d = '0;
            i_d = i_q + 1'b1;
          end
          raddr = IdxBits'(i_q + j_d);
        end
      end
      S_DD_CUT_RD: raddr = IdxBits'(used - 1'b1);
      S_DD_CUT_WAIT: raddr = IdxBits'(used - 1'b1);
      S_DD_CUT: begin
        cnt_d = used;
        fsize_d = rofs_q + OfsBits'(rhash_q[HashBits-2:32]);
        run_d = run_q;
      end
      S_LOC_RD, S_LOC_WAIT: begin
        // match: location of record i; otherwise run start
        raddr = (i_q < run_q) ? i_q[IdxBits-1:0] : run_q[IdxBits-1:0];
        if (state_q == S_LOC_WAIT) loc_d = rofs_q;
      end
      default: ;
    endcase
    if (state_q == S_OUT && err_q) loc_d = fsize_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dbs_q   <= DbsReset;
      cnt_q   <= '0;
      run_q   <= '0;
      fsize_q <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) dbs_q <= cfg_wdata_i;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      fsize_q <= fsize_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    loc_q <= loc_d; i_q <= i_d; j_q <= j_d; len_q <= len_d; ha_q <= ha_d;
    phase_q <= phase_d;
    if (state_q == S_IDLE && in_valid_i) begin
      bs_q <= block_size_i; cs_q <= checksum_i; first_q <= first_block_i;
      last_q <= last_block_i; frag_q <= fragment_block_i; sparse_q <= is_sparse_i;
      comp_q <= is_compressed_i; align_q <= align_i; nodd_q <= no_dedup_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign location_o  = err_q ? fsize_q : loc_q;
  assign image_end_o = fsize_q;
  assign status_o    = err_q;
endmodule

@@ design/brdw_mod.sv @@
// Restoring bit-serial modulo unit: 48-bit dividend mod 21-bit divisor, one bit a cycle.
// Depends on brdw_pkg.
module brdw_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  brdw_pkg::mod_req_t           req_i,
  input  logic [brdw_pkg::OfsBits-1:0] dividend_i,
  input  logic [brdw_pkg::DbsBits-1:0] divisor_i,
  output brdw_pkg::mod_rsp_t           rsp_o
);
  import brdw_pkg::*;

  localparam int CBits = $clog2(OfsBits + 1);

  logic [OfsBits-1:0] num_q, num_d;
  logic [DbsBits:0]   rem_q, rem_d;
  logic [CBits-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DbsBits:0]   shifted;

  always_comb begin
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[DbsBits-1:0], num_q[OfsBits-1]};
    if (req_i.start) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CBits'(OfsBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[OfsBits-2:0], 1'b0};
      rem_d = (shifted >= {1'b0, divisor_i}) ? shifted - {1'b0, divisor_i} : shifted;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, rem: rem_q[DbsBits-1:0]};
endmodule

@@ design/brdw_checker.sv @@
// Port-level checker for the block run dedup writer, bound to the top level.
// Depends on block_run_dedup_writer_defines.svh.
`include "block_run_dedup_writer_defines.svh"
module brdw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic status_o,
  input logic [47:0] image_end_o
);
  `BRDW_ASSERT(a_excl, 1'b1, !(in_ready_o && out_valid_o))
  `BRDW_ASSERT_NXT(a_busy, in_valid_i && in_ready_o, !in_ready_o)
  `BRDW_ASSERT_NXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(image_end_o))
  `BRDW_ASSERT_NXT(a_stat, out_valid_o && !out_ready_i, $stable(status_o))
  `BRDW_ASSERT_NXT(a_free, out_valid_o && out_ready_i, in_ready_o)
endmodule

bind block_run_dedup_writer brdw_checker u_brdw_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .status_o,
  .image_end_o
);

@@ tb/block_run_dedup_writer_test.sv @@
// Self-checking bench for block_run_dedup_writer: directed beats, then file-shaped
// random traffic over several device block sizes. Results are checked against a local model.
// Depends on brdw_pkg and the block_run_dedup_writer RTL.
module block_run_dedup_writer_test;
  import brdw_pkg::*;

  localparam int unsigned CycleLimit = 30000000;
  localparam int unsigned NumDirected = 15;
  localparam int unsigned NumPool = 8;
  // flag bits of a stimulus row: {first, last, frag, sparse, comp, align, no_dedup}
  localparam logic [6:0] F_FIRST  = 7'b1000000;
  localparam logic [6:0] F_LAST   = 7'b0100000;
  localparam logic [6:0] F_FRAG   = 7'b0010000;
  localparam logic [6:0] F_SPARSE = 7'b0001000;
  localparam logic [6:0] F_COMP   = 7'b0000100;
  localparam logic [6:0] F_ALIGN  = 7'b0000010;
  localparam logic [6:0] F_NODD   = 7'b0000001;

  typedef struct packed {
    logic [SizeBits-1:0] size;
    logic [31:0]         csum;
    logic [6:0]          flags;
  } blk_t;

  typedef struct packed {
    logic [OfsBits-1:0] loc;
    logic [OfsBits-1:0] img_end;
    logic               status;
  } wr_res_t;

  typedef struct packed {
    blk_t    blk;
    logic    typed;
    wr_res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [DbsBits-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  blk_t cur = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OfsBits-1:0] location_o, image_end_o;
  logic status_o;

  block_run_dedup_writer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .block_size_i    (cur.size),
    .checksum_i      (cur.csum),
    .first_block_i   (cur.flags[6]),
    .last_block_i    (cur.flags[5]),
    .fragment_block_i(cur.flags[4]),
    .is_sparse_i     (cur.flags[3]),
    .is_compressed_i (cur.flags[2]),
    .align_i         (cur.flags[1]),
    .no_dedup_i      (cur.flags[0]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .location_o      (location_o),
    .image_end_o     (image_end_o),
    .status_o        (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // image model
  logic [OfsBits-1:0]  rec_ofs [TableDepth];
  logic [HashBits-1:0] rec_hash [TableDepth];
  int unsigned n_rec = 0, run_first = 0;
  logic [OfsBits-1:0] img_end = '0;
  logic [DbsBits-1:0] dbs = DbsReset;

  wr_res_t pending_q [$];
  row_t dir_rows [NumDirected];
  int unsigned n_in = 0, n_out = 0, n_err = 0, n_full = 0, n_folds = 0;
  longint unsigned cycles = 0;
  bit quiet_tx = 0, quiet_rx = 0, long_hold = 0;

  function automatic bit add_rec(logic [OfsBits-1:0] ofs, logic [HashBits-1:0] h);
    if (n_rec >= TableDepth) return 0;
    rec_ofs[n_rec] = ofs;
    rec_hash[n_rec] = h;
    n_rec++;
    return 1;
  endfunction

  function automatic bit pad_img(bit al);
    longint unsigned rem;
    logic [OfsBits-1:0] start;
    if (!al || dbs == 0) return 1;
    rem = longint'(img_end) % longint'(dbs);
    if (rem == 0) return 1;
    start = img_end;
    img_end = img_end + OfsBits'(longint'(dbs) - rem);
    return add_rec(start, '0);
  endfunction

  function automatic logic [OfsBits-1:0] fold_run(bit nodd);
    int unsigned cnt, i, j, used;
    if (n_rec <= run_first) return '0;
    cnt = n_rec - run_first;
    if (nodd) return rec_ofs[run_first];
    for (i = 0; i < run_first; i++) begin
      for (j = 0; j < cnt; j++)
        if (rec_hash[i+j] == 0 || rec_hash[i+j] != rec_hash[run_first+j]) break;
      if (j == cnt) break;
    end
    if (i >= run_first) return rec_ofs[run_first];
    used = (cnt >= run_first - i) ? i + cnt : run_first;
    n_rec = used;
    img_end = rec_ofs[used-1] + OfsBits'(rec_hash[used-1][55:32]);
    n_folds++;
    return rec_ofs[i];
  endfunction

  function automatic wr_res_t write_block(blk_t b);
    wr_res_t r;
    bit ok;
    ok = 1;
    if (b.flags[6] || b.flags[4]) begin
      ok = pad_img(b.flags[1]);
      if (ok && b.flags[6]) run_first = n_rec;
    end
    r.loc = img_end;
    if (ok && b.size != 0 && !b.flags[3]) begin
      ok = add_rec(img_end, {~b.flags[2], b.size, b.csum});
      if (ok) img_end = img_end + OfsBits'(b.size);
    end
    if (ok && (b.flags[5] || b.flags[4])) begin
      ok = pad_img(b.flags[1]);
      if (ok && b.flags[5]) r.loc = fold_run(b.flags[0]);
    end
    if (!ok) r.loc = img_end;
    r.img_end = img_end;
    r.status = !ok;
    return r;
  endfunction

  // accepted input beats feed the model
  always @(posedge clk_i) begin
    wr_res_t r;
    if (in_valid_i && in_ready_o) begin
      r = write_block(cur);
      if (n_in < NumDirected && dir_rows[n_in].typed && r != dir_rows[n_in].res) begin
        $display("%0t: row %0d model exp %h got %h", $time, n_in, dir_rows[n_in].res, r);
        n_err++;
      end
      if (r.status) n_full++;
      pending_q.push_back(r);
      n_in++;
    end
  end

  always @(posedge clk_i) begin
    wr_res_t e;
    if (out_valid_o && out_ready_i) begin
      n_out++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat loc %h end %h status %b", $time,
                 location_o, image_end_o, status_o);
        n_err++;
      end else begin
        e = pending_q.pop_front();
        if (location_o != e.loc) begin
          $display("%0t: location exp %h got %h", $time, e.loc, location_o);
          n_err++;
        end
        if (image_end_o != e.img_end) begin
          $display("%0t: image_end exp %h got %h", $time, e.img_end, image_end_o);
          n_err++;
        end
        if (status_o != e.status) begin
          $display("%0t: status exp %b got %b", $time, e.status, status_o);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("block_run_dedup_writer: mismatch");
      $finish;
    end
  end

  // receiver
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end
      gap = quiet_rx ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_blk(blk_t b);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cur <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_dbs(logic [DbsBits-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dbs = v;
  endtask

  function automatic logic [SizeBits-1:0] pick_size();
    case ($urandom_range(0, 3))
      0: return SizeBits'($urandom_range(1, 5000));
      1: return SizeBits'(4096 * $urandom_range(1, 4));
      2: return SizeBits'($urandom_range(1, 24'hFFFFFF));
      default: return SizeBits'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic row_t mk(logic [SizeBits-1:0] s, logic [31:0] c, logic [6:0] f);
    row_t r;
    r = '0;
    r.blk = '{size: s, csum: c, flags: f};
    return r;
  endfunction

  function automatic row_t mk_exp(logic [SizeBits-1:0] s, logic [31:0] c, logic [6:0] f,
                                  logic [OfsBits-1:0] l, logic [OfsBits-1:0] e);
    row_t r;
    r = mk(s, c, f);
    r.typed = 1;
    r.res = '{loc: l, img_end: e, status: 1'b0};
    return r;
  endfunction

  int unsigned tpl_n [NumPool];
  blk_t tpl_blk [NumPool][4];

  initial begin
    logic [DbsBits-1:0] phase_dbs [6];
    int unsigned sent, k, t, nb;
    blk_t b;
    bit fresh;

    dir_rows[0]  = mk_exp(0, 0, F_FIRST | F_ALIGN, 0, 0);
    dir_rows[1]  = mk_exp(100, 32'hFFFF_FFFF, '0, 0, 100);
    dir_rows[2]  = mk_exp(24'hFF_FFFF, 0, F_COMP | F_LAST, 0, 48'd16777315);
    dir_rows[3]  = mk(500, 1, F_FIRST | F_ALIGN);
    dir_rows[4]  = mk(700, 2, F_SPARSE);
    dir_rows[5]  = mk(300, 3, F_FRAG | F_ALIGN);
    dir_rows[6]  = mk(100, 32'hFFFF_FFFF, F_LAST | F_NODD);
    dir_rows[7]  = mk(0, 0, F_FIRST);
    dir_rows[8]  = mk(0, 0, F_LAST);          // empty run
    dir_rows[9]  = mk(100, 32'hFFFF_FFFF, F_FIRST);
    dir_rows[10] = mk(24'hFF_FFFF, 0, F_COMP | F_LAST);  // repeat of the first file
    dir_rows[11] = mk(4096, 5, F_FIRST | F_ALIGN);
    dir_rows[12] = mk(4096, 6, F_LAST | F_ALIGN);       // no earlier run matches, so the run is not folded
    dir_rows[13] = mk(1, 7, F_FIRST | F_LAST | F_FRAG | F_ALIGN);
    dir_rows[14] = mk(24'h80_0000, 32'h8000_0000, F_FRAG | F_COMP | F_ALIGN | F_NODD);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) send_blk(dir_rows[i].blk);

    for (int p = 0; p < NumPool; p++) begin
      tpl_n[p] = $urandom_range(1, 4);
      for (int q = 0; q < 4; q++)
        tpl_blk[p][q] = '{size: pick_size(), csum: $urandom(),
                          flags: ($urandom_range(0, 1) ? F_COMP : 7'b0)};
    end

    phase_dbs = '{DbsBits'(1), DbsBits'(1048576), DbsBits'(0), DbsBits'(4096),
                  DbsBits'($urandom_range(2, 1048576)), DbsBits'(3)};
    foreach (phase_dbs[ph]) begin
      set_dbs(phase_dbs[ph]);
      if (ph == 0) long_hold = 1;   // receiver stalls while beats keep coming
      sent = 0;
      while (sent < 235) begin
        if (sent % 60 == 0) begin
          quiet_tx = ($urandom_range(0, 3) == 0);
          quiet_rx = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 99) < 15) begin
          b = '{size: ($urandom_range(0, 5) == 0) ? '0 : pick_size(), csum: $urandom(),
                flags: 7'($urandom())};
          send_blk(b);
          sent++;
        end else begin
          fresh = ($urandom_range(0, 9) < 3);
          t = $urandom_range(0, NumPool - 1);
          nb = fresh ? $urandom_range(1, 4) : tpl_n[t];
          for (k = 0; k < nb; k++) begin
            if (fresh)
              b = '{size: pick_size(), csum: $urandom(),
                    flags: ($urandom_range(0, 1) ? F_COMP : 7'b0)};
            else
              b = tpl_blk[t][k];
            if (k == 0) b.flags |= F_FIRST | ($urandom_range(0, 1) ? F_ALIGN : 7'b0);
            if (k == nb - 1) begin
              b.flags |= F_LAST;
              if ($urandom_range(0, 3) == 0) b.flags |= F_ALIGN;
              if ($urandom_range(0, 9) == 0) b.flags |= F_NODD;
            end
            if ($urandom_range(0, 19) == 0) b.flags |= F_SPARSE;
            send_blk(b);
            sent++;
          end
        end
      end
    end

    // fill the record table, then beats that run into it
    set_dbs(DbsBits'(4096));
    quiet_tx = 0;
    quiet_rx = 0;
    send_blk('{size: 24'd10, csum: $urandom(), flags: F_FIRST});
    while (n_rec < TableDepth)
      send_blk('{size: SizeBits'($urandom_range(1, 3000)), csum: $urandom(), flags: F_COMP});
    send_blk('{size: 24'd7, csum: $urandom(), flags: '0});
    send_blk('{size: 24'd7, csum: $urandom(), flags: F_FIRST | F_ALIGN});
    send_blk('{size: 24'd0, csum: 0, flags: F_FRAG | F_ALIGN});
    send_blk('{size: 24'd9, csum: $urandom(), flags: F_LAST | F_NODD});
    send_blk('{size: 24'd9, csum: 0, flags: F_SPARSE | F_LAST | F_NODD});
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d beats in, %0d results, %0d runs folded, %0d table-full results",
             n_in, n_out, n_folds, n_full);
    $display("device block sizes 4096, 1, 1048576, 0, %0d and 3 exercised", phase_dbs[4]);
    if (n_err == 0) begin
      $display("block_run_dedup_writer: match");
    end else begin
      $display("block_run_dedup_writer: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/brdw_pkg.sv
design/brdw_mod.sv
design/block_run_dedup_writer.sv
design/brdw_checker.sv
tb/block_run_dedup_writer_test.sv
